// ----- design/assert_macros.svh -----
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/lfgde_pkg.sv -----
// types, constants and the gamma curve of the led fade engine
`default_nettype none

package lfgde_pkg;

    localparam int GAMMA_ENTRIES = 32;

    // inverted gamma 2.5 curve, 7.8 position indexes it
    localparam logic [15:0] GAMMA_TABLE [GAMMA_ENTRIES] = '{
        16'hff00, 16'hfef4, 16'hfebb, 16'hfe42, 16'hfd79, 16'hfc56, 16'hfacc, 16'hf8d2,
        16'hf65f, 16'hf36a, 16'hefed, 16'hebde, 16'he738, 16'he1f3, 16'hdc0a, 16'hd575,
        16'hce2f, 16'hc632, 16'hbd78, 16'hb3fc, 16'ha9b8, 16'h9ea8, 16'h92c6, 16'h860e,
        16'h787a, 16'h6a06, 16'h5aad, 16'h4a6a, 16'h393a, 16'h2718, 16'h13ff, 16'hffeb
    };

    localparam logic [1:0]  REG_MAX_LEVEL     = 2'd0;
    localparam logic [1:0]  REG_DITHER_MASK   = 2'd1;
    localparam logic [1:0]  REG_FADE_RATE     = 2'd2;

    localparam logic [14:0] MAX_LEVEL_RESET   = 15'd7680;
    localparam logic [7:0]  DITHER_MASK_RESET = 8'hff;
    localparam logic [15:0] FADE_RATE_RESET   = 16'h0000;
    localparam logic [15:0] FADE_CLOCK_RESET  = 16'h8000;
    localparam logic [7:0]  DITHER_STRIDE     = 8'd26;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_SET_CLOCK = 2'd1,
        OP_FRAME     = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FRAME,
        ST_DRAIN
    } back_state_t;

    typedef struct packed {
        opcode_t            op;
        logic [5:0]         channel;
        logic signed [15:0] level;
        logic signed [15:0] step;
        logic [15:0]        fade_position;
    } cmd_t;

    typedef struct packed {
        logic [14:0] max_level;
        logic [7:0]  dither_mask;
        logic [15:0] fade_rate;
    } cfg_t;

    // table read with the index held at the last entry
    function automatic logic [15:0] gamma_value(input logic [8:0] idx);
        logic [4:0] k;
        k = (idx >= 9'(GAMMA_ENTRIES)) ? 5'(GAMMA_ENTRIES - 1) : idx[4:0];
        return GAMMA_TABLE[k];
    endfunction

endpackage

`default_nettype wire

// ----- design/led_fade_gamma_dither_engine_unit.sv -----
// top level of the led fade engine: register port, intake, queue, execution
//
//  port group   direction   fields (low bit up)                               accepted when
//  s_*          in          tuser: opcode; tdata: channel, level, step,      s_tvalid && s_tready
//                           fade_position
//  m_*          out         tdata: pixel_byte, out_channel; tlast: last      m_tvalid && m_tready
//  apb          in          max_level @0, dither_mask @4, fade_rate @8       psel && penable && pwrite
//
//  a load or clock set is taken from the queue in the idle state; a frame sweeps all CHANNELS
//  channels, one channel per cycle unless m_tready stalls, through the single write port
//  of the channel memories (read, multiply, clamp, lerp, write back).
//  after reset a clearing pass over every channel seeds the channel memories; s_tready
//  stays low until it ends, register writes are taken throughout.
//  a stall on m_tready freezes the frame pipeline; the request queue keeps taking input
//  until its four entries are full.
`default_nettype none
`include "assert_macros.svh"

module led_fade_gamma_dither_engine_unit #(
    parameter int CHANNELS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // channel[5:0], level[21:6], step[37:22], fade_position[53:38]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    // output bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pixel_byte[7:0], out_channel[13:8]
    output logic             m_tlast,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [5:0] LAST_OUT = 6'(CHANNELS - 1);

    logic [14:0] max_level_reg, max_level_next;
    logic [7:0]  dither_mask_reg, dither_mask_next;
    logic [15:0] fade_rate_reg, fade_rate_next;
    logic        cfg_wr;

    lfgde_pkg::cfg_t cfg;
    lfgde_pkg::cmd_t push_cmd;
    lfgde_pkg::cmd_t head;
    logic            push;
    logic            fifo_full;
    logic            head_valid;
    logic            cmd_pop;
    logic            clearing;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        max_level_next   = max_level_reg;
        dither_mask_next = dither_mask_reg;
        fade_rate_next   = fade_rate_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                lfgde_pkg::REG_MAX_LEVEL:   max_level_next   = pwdata[14:0];
                lfgde_pkg::REG_DITHER_MASK: dither_mask_next = pwdata[7:0];
                lfgde_pkg::REG_FADE_RATE:   fade_rate_next   = pwdata[15:0];
                default:                    fade_rate_next   = fade_rate_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lfgde_pkg::REG_MAX_LEVEL:   prdata = {17'b0, max_level_reg};
            lfgde_pkg::REG_DITHER_MASK: prdata = {24'b0, dither_mask_reg};
            lfgde_pkg::REG_FADE_RATE:   prdata = {16'b0, fade_rate_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg   <= lfgde_pkg::MAX_LEVEL_RESET;
            dither_mask_reg <= lfgde_pkg::DITHER_MASK_RESET;
            fade_rate_reg   <= lfgde_pkg::FADE_RATE_RESET;
        end else begin
            max_level_reg   <= max_level_next;
            dither_mask_reg <= dither_mask_next;
            fade_rate_reg   <= fade_rate_next;
        end
    end

    always_comb begin
        cfg.max_level   = max_level_reg;
        cfg.dither_mask = dither_mask_reg;
        cfg.fade_rate   = fade_rate_reg;
    end

    lfgde_front #(.CHANNELS(CHANNELS)) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lfgde_cmd_fifo u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lfgde_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (head_valid),
        .cmd       (head),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // the frame marker sits only on the highest channel
    `ASSERT_IMPLIES(a_last_on_top_channel, aclk, aresetn, m_tvalid && m_tlast, m_tdata[13:8] == LAST_OUT)

    // nothing leaves while the channel memories are being seeded
    `ASSERT_IMPLIES(a_no_output_while_clearing, aclk, aresetn, clearing, !m_tvalid && !s_tready)

    // a write to the clamp register lands in the next cycle
    `ASSERT_NEXT(a_max_level_write, aclk, aresetn, cfg_wr && (paddr[3:2] == lfgde_pkg::REG_MAX_LEVEL), max_level_reg == $past(pwdata[14:0]))

endmodule

`default_nettype wire

// ----- design/lfgde_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module lfgde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/lfgde_front.sv -----
// request intake: decodes the opcode and drops requests that do nothing
`default_nettype none

module lfgde_front #(
    parameter int CHANNELS = 64
) (
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [55:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire logic              clearing,
    input  wire logic              fifo_full,
    output logic                   push,
    output lfgde_pkg::cmd_t        push_cmd
);

    localparam logic [10:0] CH_LIMIT = 11'(CHANNELS);

    logic accept;
    logic in_range;
    logic keep;

    assign s_tready = !fifo_full && !clearing;
    assign accept   = s_tvalid && s_tready;
    assign in_range = {5'b0, s_tdata[5:0]} < CH_LIMIT;

    always_comb begin
        unique case (s_tuser)
            lfgde_pkg::OP_LOAD:      keep = in_range;
            lfgde_pkg::OP_SET_CLOCK: keep = 1'b1;
            lfgde_pkg::OP_FRAME:     keep = 1'b1;
            default:                 keep = 1'b0;
        endcase
    end

    assign push = accept && keep;

    always_comb begin
        push_cmd.op            = lfgde_pkg::opcode_t'(s_tuser);
        push_cmd.channel       = s_tdata[5:0];
        push_cmd.level         = $signed(s_tdata[21:6]);
        push_cmd.step          = $signed(s_tdata[37:22]);
        push_cmd.fade_position = s_tdata[53:38];
    end

endmodule

`default_nettype wire

// ----- design/lfgde_cmd_fifo.sv -----
// short request queue between intake and execution
`default_nettype none

module lfgde_cmd_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lfgde_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output lfgde_pkg::cmd_t      head
);

    lfgde_pkg::cmd_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       do_pop;

    assign full       = count_reg == 3'd4;
    assign head_valid = count_reg != 3'd0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b0, push} - {2'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/lfgde_back.sv -----
// execution: channel memory, fade clock and the per-channel frame pipeline
`default_nettype none

module lfgde_back #(
    parameter int CHANNELS = 64
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lfgde_pkg::cfg_t cfg,
    input  wire logic            cmd_valid,
    input  wire lfgde_pkg::cmd_t cmd,
    output logic                 cmd_pop,
    output logic                 clearing,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [15:0]          m_tdata,
    output logic                 m_tlast
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

    lfgde_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    dither_init_reg, dither_init_next;
    logic [15:0]   fade_clock_reg, fade_clock_next;
    logic [7:0]    dt_reg, dt_next;

    logic adv;
    logic issue;
    logic clear_we;
    logic load_we;
    logic frame_pop;
    logic cnt_last;

    // pipeline stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next, m_valid_next;

    logic [CW-1:0] s1_ch_reg, s2_ch_reg, s3_ch_reg, s4_ch_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;

    logic signed [15:0] s2_level_reg;
    logic signed [15:0] s2_step_reg, s3_step_reg, s4_step_reg;
    logic [7:0]         s2_dither_reg, s3_dither_reg, s4_dither_reg;
    logic signed [24:0] s2_prod_reg;
    logic [14:0]        s3_lvl_reg, s4_lvl_reg;
    logic [15:0]        s4_a_reg;
    logic signed [25:0] s4_mprod_reg;

    logic [7:0]  m_pixel_reg;
    logic [5:0]  m_ch_reg;
    logic        m_last_reg;

    // channel memories
    logic          ls_we, d_we;
    logic [CW-1:0] ls_waddr, d_waddr;
    logic [31:0]   ls_wdata, ls_rdata;
    logic [7:0]    d_wdata, d_rdata;

    // stage arithmetic
    logic signed [24:0] s2_prod_next;
    logic signed [17:0] s3_shift;
    logic signed [18:0] s3_sum;
    logic [14:0]        s3_lvl_next;
    logic [8:0]         s4_idx_a, s4_idx_b;
    logic [15:0]        s4_a_next, s4_b;
    logic signed [16:0] s4_diff;
    logic signed [25:0] s4_mprod_next;
    logic signed [17:0] out_lerp;
    logic [15:0]        out_corr;
    logic [9:0]         s4_ch_wide;
    logic [9:0]         load_ch_wide;
    logic [15:0]        clock_sum;

    assign adv       = !m_valid_reg || m_tready;
    assign cnt_last  = cnt_reg == LAST_CH;
    assign frame_pop = cmd_pop && (cmd.op == lfgde_pkg::OP_FRAME);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfgde_pkg::ST_CLEAR: begin
                if (cnt_last) begin
                    state_next = lfgde_pkg::ST_IDLE;
                end
            end
            lfgde_pkg::ST_IDLE: begin
                if (cmd_valid && cmd.op == lfgde_pkg::OP_FRAME) begin
                    state_next = lfgde_pkg::ST_FRAME;
                end
            end
            lfgde_pkg::ST_FRAME: begin
                if (adv && cnt_last) begin
                    state_next = lfgde_pkg::ST_DRAIN;
                end
            end
            lfgde_pkg::ST_DRAIN: begin
                if (!(s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg)) begin
                    state_next = lfgde_pkg::ST_IDLE;
                end
            end
            default: state_next = lfgde_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        clearing = 1'b0;
        cmd_pop  = 1'b0;
        issue    = 1'b0;
        clear_we = 1'b0;
        load_we  = 1'b0;
        unique case (state_reg)
            lfgde_pkg::ST_CLEAR: begin
                clearing = 1'b1;
                clear_we = 1'b1;
            end
            lfgde_pkg::ST_IDLE: begin
                cmd_pop = cmd_valid;
                load_we = cmd_valid && (cmd.op == lfgde_pkg::OP_LOAD);
            end
            lfgde_pkg::ST_FRAME: begin
                issue = adv;
            end
            lfgde_pkg::ST_DRAIN: begin
                issue = 1'b0;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    // sweep counter, reset-time dither seed, fade clock
    always_comb begin
        cnt_next         = cnt_reg;
        dither_init_next = dither_init_reg;
        fade_clock_next  = fade_clock_reg;
        dt_next          = dt_reg;
        clock_sum        = fade_clock_reg + cfg.fade_rate;
        if (clear_we || issue) begin
            cnt_next = cnt_last ? '0 : cnt_reg + CW'(1);
        end
        if (clear_we) begin
            dither_init_next = dither_init_reg + lfgde_pkg::DITHER_STRIDE;
        end
        if (cmd_pop && cmd.op == lfgde_pkg::OP_SET_CLOCK) begin
            fade_clock_next = cmd.fade_position;
        end
        if (frame_pop) begin
            if (fade_clock_reg[15]) begin
                // fade finished: clock frozen
                dt_next = 8'd0;
            end else begin
                fade_clock_next = clock_sum;
                dt_next         = clock_sum[15:8] - fade_clock_reg[15:8];
            end
        end
    end

    // memory ports
    assign load_ch_wide = {4'b0, cmd.channel};
    assign s4_ch_wide   = 10'(s4_ch_reg);

    always_comb begin
        ls_we    = clear_we || load_we || (s4_valid_reg && adv);
        d_we     = clear_we || (s4_valid_reg && adv);
        ls_waddr = s4_ch_reg;
        d_waddr  = s4_ch_reg;
        ls_wdata = {1'b0, s4_lvl_reg, s4_step_reg};
        d_wdata  = out_corr[7:0] & cfg.dither_mask;
        priority if (clear_we) begin
            ls_waddr = cnt_reg;
            d_waddr  = cnt_reg;
            ls_wdata = 32'd0;
            d_wdata  = dither_init_reg;
        end else if (load_we) begin
            ls_waddr = load_ch_wide[CW-1:0];
            ls_wdata = {cmd.level, cmd.step};
        end else begin
            ls_waddr = s4_ch_reg;
        end
    end

    lfgde_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_level_step_ram (
        .aclk  (aclk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (ls_wdata),
        .re    (issue),
        .raddr (cnt_reg),
        .rdata (ls_rdata)
    );

    lfgde_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_dither_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (issue),
        .raddr (cnt_reg),
        .rdata (d_rdata)
    );

    // stage 1: step times dt
    assign s2_prod_next = 25'($signed(ls_rdata[15:0])) * 25'($signed({1'b0, dt_reg}));

    // stage 2: move and clamp, arithmetic shift gives the floor
    always_comb begin
        s3_shift = s2_prod_reg[24:7];
        s3_sum   = {{3{s2_level_reg[15]}}, s2_level_reg} + {s3_shift[17], s3_shift};
        if (s3_sum[18]) begin
            s3_lvl_next = 15'd0;
        end else if (s3_sum[18:8] > {4'b0, cfg.max_level[14:8]}) begin
            s3_lvl_next = cfg.max_level;
        end else begin
            s3_lvl_next = s3_sum[14:0];
        end
    end

    // stage 3: table pair and slope times fraction
    always_comb begin
        s4_idx_a      = {2'b0, s3_lvl_reg[14:8]};
        s4_idx_b      = s4_idx_a + 9'd1;
        s4_a_next     = lfgde_pkg::gamma_value(s4_idx_a);
        s4_b          = lfgde_pkg::gamma_value(s4_idx_b);
        s4_diff       = $signed({1'b0, s4_b}) - $signed({1'b0, s4_a_next});
        s4_mprod_next = 26'(s4_diff) * 26'($signed({1'b0, s3_lvl_reg[7:0]}));
    end

    // stage 4: lerp plus dither
    always_comb begin
        out_lerp = $signed({2'b0, s4_a_reg}) + s4_mprod_reg[25:8];
        out_corr = out_lerp[15:0] + {8'b0, s4_dither_reg};
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        s4_valid_next = s4_valid_reg;
        m_valid_next  = m_valid_reg;
        if (adv) begin
            s1_valid_next = issue;
            s2_valid_next = s1_valid_reg;
            s3_valid_next = s2_valid_reg;
            s4_valid_next = s3_valid_reg;
            m_valid_next  = s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lfgde_pkg::ST_CLEAR;
            cnt_reg         <= '0;
            dither_init_reg <= 8'd0;
            fade_clock_reg  <= lfgde_pkg::FADE_CLOCK_RESET;
            dt_reg          <= 8'd0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            dither_init_reg <= dither_init_next;
            fade_clock_reg  <= fade_clock_next;
            dt_reg          <= dt_next;
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            s3_valid_reg    <= s3_valid_next;
            s4_valid_reg    <= s4_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ch_reg     <= cnt_reg;
            s1_last_reg   <= cnt_last;

            s2_ch_reg     <= s1_ch_reg;
            s2_last_reg   <= s1_last_reg;
            s2_level_reg  <= $signed(ls_rdata[31:16]);
            s2_step_reg   <= $signed(ls_rdata[15:0]);
            s2_dither_reg <= d_rdata;
            s2_prod_reg   <= s2_prod_next;

            s3_ch_reg     <= s2_ch_reg;
            s3_last_reg   <= s2_last_reg;
            s3_step_reg   <= s2_step_reg;
            s3_dither_reg <= s2_dither_reg;
            s3_lvl_reg    <= s3_lvl_next;

            s4_ch_reg     <= s3_ch_reg;
            s4_last_reg   <= s3_last_reg;
            s4_step_reg   <= s3_step_reg;
            s4_dither_reg <= s3_dither_reg;
            s4_lvl_reg    <= s3_lvl_reg;
            s4_a_reg      <= s4_a_next;
            s4_mprod_reg  <= s4_mprod_next;

            m_pixel_reg   <= out_corr[15:8];
            m_ch_reg      <= s4_ch_wide[5:0];
            m_last_reg    <= s4_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b0, m_ch_reg, m_pixel_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the led fade gamma dither engine
module tb_top;

    localparam int CHANNELS         = 64;
    localparam int DRAIN_CYCLES     = 2 * CHANNELS + 32;
    localparam int ITEMS_PER_PHASE  = 66;
    localparam int PHASES           = 5;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int NO_FIXED_BYTE    = -1;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct {
        bit                 is_reg;
        logic [1:0]         op;
        logic [1:0]         reg_idx;
        logic [31:0]        value;      // fade position, or register value
        logic [5:0]         channel;
        logic signed [15:0] level;
        logic signed [15:0] step;
        int                 fixed_byte;
    } stim_row_t;

    typedef struct {
        logic [7:0] pixel;
        logic [5:0] channel;
        logic       last;
    } pixel_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [31:0] prdata;
    logic        pready;

    led_fade_gamma_dither_engine_unit #(.CHANNELS(CHANNELS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic signed [15:0] level_mem  [CHANNELS];
    logic signed [15:0] step_mem   [CHANNELS];
    logic [7:0]         dither_mem [CHANNELS];
    logic [15:0]        fade_clk;
    logic [14:0]        max_level_q;
    logic [7:0]         mask_q;
    logic [15:0]        rate_q;

    pixel_out_t pixel_queue[$];
    int mismatches = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic void reset_model();
        for (int c = 0; c < CHANNELS; c++) begin
            level_mem[c]  = '0;
            step_mem[c]   = '0;
            dither_mem[c] = 8'((c * 26) % 256);
        end
        fade_clk    = lfgde_pkg::FADE_CLOCK_RESET;
        max_level_q = lfgde_pkg::MAX_LEVEL_RESET;
        mask_q      = lfgde_pkg::DITHER_MASK_RESET;
        rate_q      = lfgde_pkg::FADE_RATE_RESET;
    endfunction

    function automatic int gamma_at(int idx);
        return int'(lfgde_pkg::GAMMA_TABLE[(idx >= lfgde_pkg::GAMMA_ENTRIES) ?
                                           lfgde_pkg::GAMMA_ENTRIES - 1 : idx]);
    endfunction

    function automatic void predict_frame();
        logic [7:0]  dt;
        logic [15:0] next_clk;
        logic [15:0] corr;
        int v, h, t, a, b, lerp;
        dt = '0;
        // a clock at 0x80xx or above is frozen
        if (fade_clk[15:8] < 8'h80) begin
            next_clk = fade_clk + rate_q;
            dt       = next_clk[15:8] - fade_clk[15:8];
            fade_clk = next_clk;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            v = int'(level_mem[c]) + ((int'(step_mem[c]) * int'(dt)) >>> 7);
            if (v < 0)
                v = 0;
            else if ((v >>> 8) > int'(max_level_q >> 8))
                v = int'(max_level_q);
            level_mem[c] = 16'(v);
            h    = (v >>> 8) & 255;
            t    = v & 255;
            a    = gamma_at(h);
            b    = gamma_at(h + 1);
            lerp = a + (((b - a) * t) >>> 8);
            corr = 16'(lerp + int'(dither_mem[c]));
            dither_mem[c] = corr[7:0] & mask_q;
            pixel_queue.push_back('{corr[15:8], 6'(c), (c == CHANNELS - 1)});
        end
    endfunction

    function automatic void apply_request(stim_row_t r);
        case (r.op)
            lfgde_pkg::OP_LOAD: begin
                level_mem[r.channel] = r.level;
                step_mem[r.channel]  = r.step;
            end
            lfgde_pkg::OP_SET_CLOCK: fade_clk = r.value[15:0];
            lfgde_pkg::OP_FRAME:     predict_frame();
            default: ;
        endcase
    endfunction

    function automatic stim_row_t mk_item(logic [1:0] op, logic [5:0] ch, logic [15:0] lvl,
                                          logic [15:0] stp, logic [15:0] fpos, int fixed);
        stim_row_t r;
        r.is_reg     = 1'b0;
        r.op         = op;
        r.reg_idx    = '0;
        r.value      = {16'h0, fpos};
        r.channel    = ch;
        r.level      = lvl;
        r.step       = stp;
        r.fixed_byte = fixed;
        return r;
    endfunction

    function automatic stim_row_t mk_reg(logic [1:0] idx, logic [31:0] val);
        stim_row_t r;
        r         = mk_item(OP_NONE, '0, '0, '0, '0, NO_FIXED_BYTE);
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t r;
        int pick;
        int k;
        r = mk_item(OP_NONE, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    NO_FIXED_BYTE);
        pick = $urandom_range(99);
        if (pick < 40) begin
            r.op = lfgde_pkg::OP_LOAD;
            k = $urandom_range(9);
            if (k < 6)
                r.level = 16'($urandom_range(0, int'(max_level_q) + 512));
            else if (k == 8)
                case ($urandom_range(3))
                    0: r.level = 16'h0000;
                    1: r.level = 16'h7fff;
                    2: r.level = 16'h8000;
                    default: r.level = 16'(max_level_q);
                endcase
            if ($urandom_range(1) == 0)
                r.step = 16'($urandom_range(0, 1023) - 512);
        end else if (pick < 52) begin
            r.op = lfgde_pkg::OP_SET_CLOCK;
            // mostly a running fade clock, sometimes a frozen one
            if ($urandom_range(3) != 0)
                r.value = 32'($urandom_range(0, 16'h7fff));
        end else if (pick < 95) begin
            r.op = lfgde_pkg::OP_FRAME;
        end
        return r;
    endfunction

    task automatic send_request(input stim_row_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {2'b00, r.value[15:0], r.step, r.level, r.channel};
        do @(posedge aclk); while (!s_tready);
        apply_request(r);
    endtask

    // stop sending, wait for every expected byte, then let the block settle
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lfgde_pkg::REG_MAX_LEVEL:   max_level_q = val[14:0];
            lfgde_pkg::REG_DITHER_MASK: mask_q      = val[7:0];
            lfgde_pkg::REG_FADE_RATE:   rate_q      = val[15:0];
            default: ;
        endcase
    endtask

    // output checker and receiver stall
    always @(posedge aclk) begin
        pixel_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("unexpected byte: pixel %0h channel %0d last %0b",
                             m_tdata[7:0], m_tdata[13:8], m_tlast);
            end else begin
                want = pixel_queue.pop_front();
                if (m_tdata[7:0] !== want.pixel || m_tdata[13:8] !== want.channel ||
                        m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("mismatch: expected pixel %0h channel %0d last %0b, %s %0h %0d %0b",
                                 want.pixel, want.channel, want.last, "got",
                                 m_tdata[7:0], m_tdata[13:8], m_tlast);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        stim_row_t directed[$];
        reset_model();

        // after reset every level is 0, so every byte is the top of the table
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0, 8'hff));
        directed.push_back(mk_reg(lfgde_pkg::REG_MAX_LEVEL, 32'd32767));
        directed.push_back(mk_reg(lfgde_pkg::REG_FADE_RATE, 32'h0100));
        directed.push_back(mk_item(lfgde_pkg::OP_LOAD, 6'd0, 16'h0000, 16'h7fff, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_LOAD, 6'd63, 16'h8000, 16'h8000, 16'h0,
                                   NO_FIXED_BYTE));
        // top of range holds both table indexes at the last entry
        directed.push_back(mk_item(lfgde_pkg::OP_LOAD, 6'd1, 16'h7fff, 16'h0000, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_LOAD, 6'd2, 16'h1f80, 16'h0000, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_LOAD, 6'd3, 16'h1e80, 16'hff00, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_SET_CLOCK, 6'd0, 16'h0, 16'h0, 16'h0000,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));
        // unused opcode with the data bits all high: no bytes
        directed.push_back(mk_item(OP_NONE, 6'h3f, 16'hffff, 16'hffff, 16'hffff, NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_SET_CLOCK, 6'd0, 16'h0, 16'h0, 16'h7fff,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_SET_CLOCK, 6'd0, 16'h0, 16'h0, 16'hffff,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));
        // clock wraps backwards by one, high byte jump of 255
        directed.push_back(mk_reg(lfgde_pkg::REG_FADE_RATE, 32'hffff));
        directed.push_back(mk_item(lfgde_pkg::OP_SET_CLOCK, 6'd0, 16'h0, 16'h0, 16'h0000,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));
        directed.push_back(mk_reg(lfgde_pkg::REG_MAX_LEVEL, 32'd0));
        directed.push_back(mk_reg(lfgde_pkg::REG_DITHER_MASK, 32'd0));
        directed.push_back(mk_item(lfgde_pkg::OP_FRAME, 6'd0, 16'h0, 16'h0, 16'h0,
                                   NO_FIXED_BYTE));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_reg) begin
                drain(DRAIN_CYCLES);
                write_reg(directed[i].reg_idx, directed[i].value);
            end else begin
                send_request(directed[i]);
                if (directed[i].fixed_byte != NO_FIXED_BYTE)
                    for (int k = pixel_queue.size() - CHANNELS; k < pixel_queue.size(); k++)
                        pixel_queue[k].pixel = 8'(directed[i].fixed_byte);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain(DRAIN_CYCLES);
            case (p)
                0: begin
                    write_reg(lfgde_pkg::REG_MAX_LEVEL, 32'd32767);
                    write_reg(lfgde_pkg::REG_DITHER_MASK, 32'hff);
                    write_reg(lfgde_pkg::REG_FADE_RATE, 32'h0400);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_reg(lfgde_pkg::REG_MAX_LEVEL, 32'd0);
                    write_reg(lfgde_pkg::REG_DITHER_MASK, 32'h00);
                    write_reg(lfgde_pkg::REG_FADE_RATE, 32'hffff);
                    idle_pct  = 77;
                    stall_pct = 0;
                end
                2: begin
                    write_reg(lfgde_pkg::REG_MAX_LEVEL, 32'd7680);
                    write_reg(lfgde_pkg::REG_DITHER_MASK, 32'h0f);
                    write_reg(lfgde_pkg::REG_FADE_RATE, 32'h0100);
                    idle_pct  = 0;
                    stall_pct = 77;
                end
                3: begin
                    write_reg(lfgde_pkg::REG_MAX_LEVEL, 32'($urandom_range(0, 32767)));
                    write_reg(lfgde_pkg::REG_DITHER_MASK, 32'($urandom_range(0, 255)));
                    write_reg(lfgde_pkg::REG_FADE_RATE, 32'($urandom_range(0, 65535)));
                    idle_pct  = 35;
                    stall_pct = 35;
                end
                default: begin
                    write_reg(lfgde_pkg::REG_MAX_LEVEL, 32'($urandom_range(0, 32767)));
                    write_reg(lfgde_pkg::REG_DITHER_MASK, 32'ha5);
                    write_reg(lfgde_pkg::REG_FADE_RATE, 32'h2000);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // hold off mid-phase until the output side has caught up
                if (n == ITEMS_PER_PHASE / 2)
                    drain(1);
                send_request(rand_row());
            end
        end

        drain(DRAIN_CYCLES);
        if (mismatches == 0 && pixel_queue.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/lfgde_pkg.sv
design/lfgde_ram.sv
design/lfgde_front.sv
design/lfgde_cmd_fifo.sv
design/lfgde_back.sv
design/led_fade_gamma_dither_engine_unit.sv
tb/sv/tb_top.sv
